>>> sv/lrhm_pkg.sv
// Shared types and constants of the leased rail hold manager.
// Holds reset values, register indexes and function codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrhm_pkg;

    localparam int RAILS_DEF = 4;
    localparam int USERS_DEF = 8;

    localparam int DATA_W = 32;

    localparam logic [DATA_W-1:0] LEASE_TICKS_RST = 32'd3000;
    localparam logic [DATA_W-1:0] QUIET_TICKS_RST = 32'd5000;
    localparam logic [2:0]        HOST_USER_RST   = 3'd0;
    localparam logic [1:0]        AFE_RAIL_RST    = 2'd0;

    // configuration register indexes
    localparam logic [1:0] CFG_LEASE_TICKS = 2'd0;
    localparam logic [1:0] CFG_QUIET_TICKS = 2'd1;
    localparam logic [1:0] CFG_HOST_USER   = 2'd2;
    localparam logic [1:0] CFG_AFE_RAIL    = 2'd3;

    typedef enum logic [2:0] {
        FN_ACQUIRE     = 3'd0,
        FN_RELEASE     = 3'd1,
        FN_HOLDS       = 3'd2,
        FN_STATE       = 3'd3,
        FN_POLL        = 3'd4,
        FN_RELEASE_ALL = 3'd5
    } func_t;

endpackage

`default_nettype wire

>>> sv/leased_rail_hold_manager_top.sv
// Leased rail hold manager, top level: sequencer, hold masks, lease store.
// Depends on lrhm_pkg.
//
// Operation: acquire, release, queries and release-all pass through the exec,
// drive and report states before done pulses; poll adds the host check and
// the lease walk, which reads one lease word per cycle through the one
// shared 32-bit adder. One item at a time: busy is high until done.
// done is a one-cycle strobe with no back-pressure; start may be taken in
// the same cycle. Reset (rst_n low, async) empties every rail, clears all
// leases and the host link history, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module leased_rail_hold_manager_top #(
    parameter int RAILS = lrhm_pkg::RAILS_DEF,
    parameter int USERS = lrhm_pkg::USERS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command side
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  func,
    input  wire logic [3:0]  rail,
    input  wire logic [3:0]  user,
    input  wire logic [31:0] now,
    input  wire logic        pwm_enabled,
    input  wire logic [31:0] rx_count,
    input  wire logic        afe_pin,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_idx,
    input  wire logic [31:0] cfg_wdata,
    // result side
    output logic             done,
    output logic             ok,
    output logic [7:0]       users_mask,
    output logic [3:0]       user_count,
    output logic [7:0]       leased_mask,
    output logic             is_blocked,
    output logic             rail_on,
    output logic             afe_drive
);

    localparam int RW      = (RAILS > 1) ? $clog2(RAILS) : 1;
    localparam int UW      = (USERS > 1) ? $clog2(USERS) : 1;
    localparam int ENTRIES = RAILS * USERS;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HOST,
        S_WALK,
        S_DRIVE,
        S_REPORT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] lease_ticks_reg;
    logic [31:0] quiet_ticks_reg;
    logic [2:0]  host_user_reg;
    logic [1:0]  afe_rail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lease_ticks_reg <= lrhm_pkg::LEASE_TICKS_RST;
            quiet_ticks_reg <= lrhm_pkg::QUIET_TICKS_RST;
            host_user_reg   <= lrhm_pkg::HOST_USER_RST;
            afe_rail_reg    <= lrhm_pkg::AFE_RAIL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                lrhm_pkg::CFG_LEASE_TICKS: lease_ticks_reg <= cfg_wdata;
                lrhm_pkg::CFG_QUIET_TICKS: quiet_ticks_reg <= cfg_wdata;
                lrhm_pkg::CFG_HOST_USER:   host_user_reg   <= cfg_wdata[2:0];
                lrhm_pkg::CFG_AFE_RAIL:    afe_rail_reg    <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t          state_reg;
    logic            busy_reg;
    logic            done_reg;

    // command word captured at accept
    lrhm_pkg::func_t func_reg;
    logic [3:0]      rail_reg;
    logic [3:0]      user_reg;
    logic [31:0]     now_reg;
    logic            pwm_reg;
    logic [31:0]     rx_reg;
    logic            pin_reg;
    logic            rail_ok_reg;
    logic            user_ok_reg;
    logic            op_ok_reg;

    // one user bitmask per rail; per-entry "lease running" flags act as the
    // valid bits of the expiry store (a clear flag reads as expiry 0)
    logic [USERS-1:0] holder_reg [RAILS];
    logic [USERS-1:0] leased_reg [RAILS];

    logic [31:0]     last_rx_reg;
    logic [31:0]     last_heard_reg;

    // lease walk: issue counters and the entry whose word is in mem_q
    logic [RW-1:0]   walk_r_reg;
    logic [UW-1:0]   walk_u_reg;
    logic            walk_more_reg;
    logic [RW-1:0]   chk_r_reg;
    logic [UW-1:0]   chk_u_reg;
    logic            chk_vld_reg;

    // registered result word
    logic            ok_reg;
    logic [7:0]      users_mask_reg;
    logic [3:0]      user_count_reg;
    logic [7:0]      leased_mask_reg;
    logic            is_blocked_reg;
    logic            rail_on_reg;
    logic            afe_drive_reg;

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    logic [RW-1:0] rail_idx;
    logic [UW-1:0] user_idx;
    logic [UW-1:0] host_idx;
    logic [RW-1:0] afe_idx;
    logic          host_ok;
    logic          afe_ok;
    logic          is_afe;
    logic          is_host;

    assign rail_idx = RW'(rail_reg);
    assign user_idx = UW'(user_reg);
    assign host_idx = UW'(host_user_reg);
    assign afe_idx  = RW'(afe_rail_reg);
    assign host_ok  = 32'(host_user_reg) < 32'(USERS);
    assign afe_ok   = 32'(afe_rail_reg) < 32'(RAILS);
    assign is_afe   = rail_ok_reg && afe_ok && (rail_reg == {2'b00, afe_rail_reg});
    assign is_host  = (user_reg == {1'b0, host_user_reg});

    // single row read port of the mask arrays: AFE rail in S_DRIVE, else
    // the addressed rail
    logic [RW-1:0]    row_idx;
    logic [USERS-1:0] hold_row;
    logic [USERS-1:0] lease_row;

    assign row_idx   = (state_reg == S_DRIVE) ? afe_idx : rail_idx;
    assign hold_row  = holder_reg[row_idx];
    assign lease_row = leased_reg[row_idx];

    logic had;
    logic grant;

    assign had   = hold_row[user_idx];
    assign grant = rail_ok_reg && user_ok_reg && !(!had && is_afe && pwm_reg);

    // ------------------------------------------------------------------
    // Expiry store: one write port (acquire), one registered read (walk)
    // ------------------------------------------------------------------
    logic [31:0]   exp_mem [ENTRIES];
    logic [31:0]   mem_q;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   lease_at;

    assign mem_waddr = AW'(32'(rail_idx) * 32'(USERS) + 32'(user_idx));
    assign mem_raddr = AW'(32'(walk_r_reg) * 32'(USERS) + 32'(walk_u_reg));
    assign mem_we    = (state_reg == S_EXEC) && (func_reg == lrhm_pkg::FN_ACQUIRE)
                       && grant && !is_host;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            exp_mem[mem_waddr] <= lease_at;
        end
        mem_q <= exp_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Shared adder: now + lease, now - last_heard, now - expiry
    // ------------------------------------------------------------------
    logic [31:0] alu_b;
    logic        alu_sub;
    logic [31:0] alu_sum;

    always_comb
    begin
        alu_b   = lease_ticks_reg;
        alu_sub = 1'b0;
        if (state_reg == S_HOST)
        begin
            alu_b   = last_heard_reg;
            alu_sub = 1'b1;
        end
        else if (state_reg == S_WALK)
        begin
            alu_b   = mem_q;
            alu_sub = 1'b1;
        end
    end

    assign alu_sum  = now_reg + (alu_sub ? ~alu_b : alu_b) + {31'd0, alu_sub};
    // an expiry landing on zero would read as "never", so step it to 1
    assign lease_at = (alu_sum == 32'd0) ? 32'd1 : alu_sum;

    logic host_quiet;
    logic expired;
    logic walk_last;

    assign host_quiet = (alu_sum > quiet_ticks_reg) && host_ok;
    // sign bit clear means now is at or past the expiry
    assign expired    = chk_vld_reg && leased_reg[chk_r_reg][chk_u_reg] && !alu_sum[31];
    assign walk_last  = (walk_r_reg == RW'(RAILS - 1)) && (walk_u_reg == UW'(USERS - 1));

    // population count of the addressed rail
    logic [USERS-1:0] rep_mask;
    logic [3:0]       rep_count;

    assign rep_mask = rail_ok_reg ? hold_row : '0;

    always_comb
    begin
        rep_count = 4'd0;
        for (int i = 0; i < USERS; i++)
        begin
            rep_count = rep_count + {3'd0, rep_mask[i]};
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            busy_reg        <= 1'b0;
            done_reg        <= 1'b0;
            func_reg        <= lrhm_pkg::FN_ACQUIRE;
            rail_reg        <= '0;
            user_reg        <= '0;
            now_reg         <= '0;
            pwm_reg         <= 1'b0;
            rx_reg          <= '0;
            pin_reg         <= 1'b0;
            rail_ok_reg     <= 1'b0;
            user_ok_reg     <= 1'b0;
            op_ok_reg       <= 1'b0;
            for (int r = 0; r < RAILS; r++)
            begin
                holder_reg[r] <= '0;
                leased_reg[r] <= '0;
            end
            last_rx_reg     <= '0;
            last_heard_reg  <= '0;
            walk_r_reg      <= '0;
            walk_u_reg      <= '0;
            walk_more_reg   <= 1'b0;
            chk_r_reg       <= '0;
            chk_u_reg       <= '0;
            chk_vld_reg     <= 1'b0;
            ok_reg          <= 1'b0;
            users_mask_reg  <= '0;
            user_count_reg  <= '0;
            leased_mask_reg <= '0;
            is_blocked_reg  <= 1'b0;
            rail_on_reg     <= 1'b0;
            afe_drive_reg   <= 1'b0;
        end
        else
        begin
            // strobe in the cycle after the report state
            done_reg <= (state_reg == S_REPORT);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        func_reg    <= lrhm_pkg::func_t'(func);
                        rail_reg    <= rail;
                        user_reg    <= user;
                        now_reg     <= now;
                        pwm_reg     <= pwm_enabled;
                        rx_reg      <= rx_count;
                        pin_reg     <= afe_pin;
                        rail_ok_reg <= 32'(rail) < 32'(RAILS);
                        user_ok_reg <= 32'(user) < 32'(USERS);
                        busy_reg    <= 1'b1;
                        state_reg   <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    state_reg <= S_DRIVE;
                    unique case (func_reg)
                        lrhm_pkg::FN_ACQUIRE:
                        begin
                            op_ok_reg <= grant;
                            if (grant)
                            begin
                                holder_reg[rail_idx][user_idx] <= 1'b1;
                                // host holds carry no lease
                                leased_reg[rail_idx][user_idx] <= !is_host;
                            end
                        end
                        lrhm_pkg::FN_RELEASE:
                        begin
                            op_ok_reg <= 1'b0;
                            if (rail_ok_reg && user_ok_reg)
                            begin
                                holder_reg[rail_idx][user_idx] <= 1'b0;
                                leased_reg[rail_idx][user_idx] <= 1'b0;
                            end
                        end
                        lrhm_pkg::FN_HOLDS:
                        begin
                            op_ok_reg <= rail_ok_reg && user_ok_reg && had;
                        end
                        lrhm_pkg::FN_STATE:
                        begin
                            op_ok_reg <= rail_ok_reg;
                        end
                        lrhm_pkg::FN_POLL:
                        begin
                            op_ok_reg <= 1'b1;
                            if (rx_reg != last_rx_reg)
                            begin
                                last_rx_reg    <= rx_reg;
                                last_heard_reg <= now_reg;
                            end
                            state_reg <= S_HOST;
                        end
                        lrhm_pkg::FN_RELEASE_ALL:
                        begin
                            op_ok_reg <= 1'b1;
                            for (int r = 0; r < RAILS; r++)
                            begin
                                holder_reg[r] <= '0;
                                leased_reg[r] <= '0;
                            end
                        end
                        default:
                        begin
                            op_ok_reg <= 1'b0;
                        end
                    endcase
                end

                S_HOST:
                begin
                    // host silent too long: drop its hold on every rail
                    if (host_quiet)
                    begin
                        for (int r = 0; r < RAILS; r++)
                        begin
                            holder_reg[r][host_idx] <= 1'b0;
                            leased_reg[r][host_idx] <= 1'b0;
                        end
                    end
                    walk_r_reg    <= '0;
                    walk_u_reg    <= '0;
                    walk_more_reg <= 1'b1;
                    chk_vld_reg   <= 1'b0;
                    state_reg     <= S_WALK;
                end

                S_WALK:
                begin
                    if (expired)
                    begin
                        holder_reg[chk_r_reg][chk_u_reg] <= 1'b0;
                        leased_reg[chk_r_reg][chk_u_reg] <= 1'b0;
                    end
                    if (walk_more_reg)
                    begin
                        chk_r_reg   <= walk_r_reg;
                        chk_u_reg   <= walk_u_reg;
                        chk_vld_reg <= 1'b1;
                        if (walk_last)
                        begin
                            walk_more_reg <= 1'b0;
                        end
                        if (walk_u_reg == UW'(USERS - 1))
                        begin
                            walk_u_reg <= '0;
                            walk_r_reg <= walk_r_reg + RW'(1);
                        end
                        else
                        begin
                            walk_u_reg <= walk_u_reg + UW'(1);
                        end
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b0;
                        state_reg   <= S_DRIVE;
                    end
                end

                S_DRIVE:
                begin
                    afe_drive_reg <= afe_ok && (hold_row != '0);
                    state_reg     <= S_REPORT;
                end

                S_REPORT:
                begin
                    if (func_reg == lrhm_pkg::FN_RELEASE)
                    begin
                        ok_reg <= rail_ok_reg && user_ok_reg && (hold_row == '0);
                    end
                    else
                    begin
                        ok_reg <= op_ok_reg;
                    end
                    users_mask_reg  <= 8'(rep_mask);
                    user_count_reg  <= rep_count;
                    leased_mask_reg <= 8'(rail_ok_reg ? lease_row : '0);
                    is_blocked_reg  <= is_afe && pwm_reg;
                    rail_on_reg     <= is_afe && pin_reg;
                    busy_reg        <= 1'b0;
                    state_reg       <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign ok          = ok_reg;
    assign users_mask  = users_mask_reg;
    assign user_count  = user_count_reg;
    assign leased_mask = leased_mask_reg;
    assign is_blocked  = is_blocked_reg;
    assign rail_on     = rail_on_reg;
    assign afe_drive   = afe_drive_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the strobe only comes once the sequencer has let go of busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // an accepted word always occupies the sequencer next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not raise busy");

    // a running lease always belongs to a current holder
    a_lease_held: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((leased_mask & ~users_mask) == 8'd0))
        else $error("lease reported for a user that does not hold the rail");

    // results are single-cycle strobes
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

endmodule

`default_nettype wire

>>> sim/tb_leased_rail_hold_manager_top.sv
`timescale 1ns / 1ps

// Self-checking bench for leased_rail_hold_manager_top: directed commands, then random
// command streams under several register settings, each reply checked against a model.
// Depends on lrhm_pkg and the top level RTL.

module tb_leased_rail_hold_manager_top;

    localparam int NR = lrhm_pkg::RAILS_DEF;
    localparam int NU = lrhm_pkg::USERS_DEF;

    // func codes the block leaves unused
    localparam logic [2:0] FN_SPARE_A = 3'd6;
    localparam logic [2:0] FN_SPARE_B = 3'd7;

    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 100;
    localparam int STEADY_PHASE    = 2;     // no sender gaps in this phase

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  rail;
        logic [3:0]  user;
        logic [31:0] now;
        logic        pwm;
        logic [31:0] rx;
        logic        pin;
    } command_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] users;
        logic [3:0] count;
        logic [7:0] leased;
        logic       blocked;
        logic       rail_on;
        logic       drive;
    } reply_t;

    // Model of the hold masks and lease table plus the queue of replies still owed.
    class hold_board;
        bit [31:0] lease_len;
        bit [31:0] quiet_len;
        bit [2:0]  host_idx;
        bit [1:0]  afe_idx;
        bit [7:0]  holders[NR];
        bit [31:0] expiry[NR][NU];
        bit [31:0] seen_rx;
        bit [31:0] heard_at;
        reply_t    expected_replies[$];
        int        words_in;
        int        replies_seen;
        int        errors;
        int        polls;
        int        lapsed;

        function new();
            lease_len = lrhm_pkg::LEASE_TICKS_RST;
            quiet_len = lrhm_pkg::QUIET_TICKS_RST;
            host_idx  = lrhm_pkg::HOST_USER_RST;
            afe_idx   = lrhm_pkg::AFE_RAIL_RST;
            foreach (holders[r])
                holders[r] = '0;
            foreach (expiry[r, u])
                expiry[r][u] = '0;
            seen_rx  = '0;
            heard_at = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                lrhm_pkg::CFG_LEASE_TICKS: lease_len = val;
                lrhm_pkg::CFG_QUIET_TICKS: quiet_len = val;
                lrhm_pkg::CFG_HOST_USER:   host_idx  = val[2:0];
                lrhm_pkg::CFG_AFE_RAIL:    afe_idx   = val[1:0];
            endcase
        endfunction

        function void drop(int r, int u);
            holders[r][u] = 1'b0;
            expiry[r][u]  = '0;
        endfunction

        function reply_t apply_command(command_t c);
            reply_t    y;
            bit        rail_ok;
            bit        user_ok;
            bit        is_afe;
            bit        had;
            bit [31:0] at;
            bit [31:0] age;
            y       = '0;
            rail_ok = c.rail < NR;
            user_ok = c.user < NU;
            is_afe  = rail_ok && (c.rail == afe_idx);
            case (c.func)
                lrhm_pkg::FN_ACQUIRE:
                    if (rail_ok && user_ok) begin
                        had = holders[c.rail][c.user];
                        // new holds on the AFE rail are refused while armed; renewals pass
                        if (had || !is_afe || !c.pwm) begin
                            at = c.now + lease_len;
                            if (at == 0)
                                at = 1;
                            holders[c.rail][c.user] = 1'b1;
                            expiry[c.rail][c.user] = (c.user == host_idx) ? '0 : at;
                            y.ok = 1'b1;
                        end
                    end
                lrhm_pkg::FN_RELEASE:
                    if (rail_ok && user_ok) begin
                        drop(c.rail, c.user);
                        y.ok = (holders[c.rail] == 0);
                    end
                lrhm_pkg::FN_HOLDS:
                    if (rail_ok && user_ok)
                        y.ok = holders[c.rail][c.user];
                lrhm_pkg::FN_STATE:
                    y.ok = rail_ok;
                lrhm_pkg::FN_POLL:
                    begin
                        polls++;
                        if (c.rx != seen_rx) begin
                            seen_rx  = c.rx;
                            heard_at = c.now;
                        end
                        if ((c.now - heard_at) > quiet_len && host_idx < NU)
                            for (int r = 0; r < NR; r++)
                                if (holders[r][host_idx])
                                    drop(r, host_idx);
                        // lease is over once now-expiry is non-negative as a signed value
                        for (int r = 0; r < NR; r++)
                            for (int u = 0; u < NU; u++) begin
                                at  = expiry[r][u];
                                age = c.now - at;
                                if (at != 0 && !age[31]) begin
                                    drop(r, u);
                                    lapsed++;
                                end
                            end
                        y.ok = 1'b1;
                    end
                lrhm_pkg::FN_RELEASE_ALL:
                    begin
                        foreach (expiry[r, u])
                            drop(r, u);
                        y.ok = 1'b1;
                    end
                default: ;
            endcase
            if (rail_ok) begin
                y.users = holders[c.rail];
                for (int u = 0; u < NU; u++)
                    y.leased[u] = (expiry[c.rail][u] != 0);
            end
            y.count   = 4'($countones(y.users));
            y.blocked = is_afe && c.pwm;
            y.rail_on = is_afe ? c.pin : 1'b0;
            y.drive   = (afe_idx < NR) && (holders[afe_idx] != 0);
            return y;
        endfunction

        function void note_command(command_t c);
            words_in++;
            expected_replies.push_back(apply_command(c));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (expected_replies.size() == 0) begin
                $error("reply word with no command outstanding");
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            replies_seen++;
            compare_field("ok", 32'(want.ok), 32'(got.ok));
            compare_field("users_mask", 32'(want.users), 32'(got.users));
            compare_field("user_count", 32'(want.count), 32'(got.count));
            compare_field("leased_mask", 32'(want.leased), 32'(got.leased));
            compare_field("is_blocked", 32'(want.blocked), 32'(got.blocked));
            compare_field("rail_on", 32'(want.rail_on), 32'(got.rail_on));
            compare_field("afe_drive", 32'(want.drive), 32'(got.drive));
        endfunction
    endclass

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [2:0]  func        = lrhm_pkg::FN_STATE;
    logic [3:0]  rail        = '0;
    logic [3:0]  user        = '0;
    logic [31:0] now         = '0;
    logic        pwm_enabled = 1'b0;
    logic [31:0] rx_count    = '0;
    logic        afe_pin     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [1:0]  cfg_idx     = lrhm_pkg::CFG_LEASE_TICKS;
    logic [31:0] cfg_wdata   = '0;
    logic        busy;
    logic        done;
    logic        ok;
    logic [7:0]  users_mask;
    logic [3:0]  user_count;
    logic [7:0]  leased_mask;
    logic        is_blocked;
    logic        rail_on;
    logic        afe_drive;

    hold_board   board;

    // stimulus time base and host link counter, both advanced by the random part
    logic [31:0] clock_now;
    logic [31:0] link_rx;

    // per-phase register settings, extremes included; the last phase is drawn at random
    logic [31:0] lease_set [PHASES] = '{32'd1500, 32'd0, 32'hFFFF_FFFF, 32'd800,
                                        32'h8000_0000, 32'd3000};
    logic [31:0] quiet_set [PHASES] = '{32'd4000, 32'd0, 32'hFFFF_FFFF, 32'd2500,
                                        32'd1200, 32'd5000};
    logic [2:0]  host_set  [PHASES] = '{3'd2, 3'd7, 3'd0, 3'd5, 3'd3, 3'd0};
    logic [1:0]  afe_set   [PHASES] = '{2'd1, 2'd3, 2'd0, 2'd2, 2'd3, 2'd0};

    leased_rail_hold_manager_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .rail        (rail),
        .user        (user),
        .now         (now),
        .pwm_enabled (pwm_enabled),
        .rx_count    (rx_count),
        .afe_pin     (afe_pin),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .ok          (ok),
        .users_mask  (users_mask),
        .user_count  (user_count),
        .leased_mask (leased_mask),
        .is_blocked  (is_blocked),
        .rail_on     (rail_on),
        .afe_drive   (afe_drive)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: done is a one-cycle strobe with no back-pressure, so every
    // strobe is a reply word. Outputs are read at the edge that ends the cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_reply(reply_t'{ok, users_mask, user_count, leased_mask,
                                       is_blocked, rail_on, afe_drive});
    end

    // Present one command word and hold it until the block takes it
    // (start high at an edge where busy is low). start stays high on return,
    // so back-to-back words follow with no idle gap.
    task automatic send(input logic [2:0] f, input logic [3:0] r, input logic [3:0] u,
                        input logic [31:0] t, input logic pwm, input logic [31:0] rx,
                        input logic pin);
        command_t c;
        c           = '{f, r, u, t, pwm, rx, pin};
        start       <= 1'b1;
        func        <= f;
        rail        <= r;
        user        <= u;
        now         <= t;
        pwm_enabled <= pwm;
        rx_count    <= rx;
        afe_pin     <= pin;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_command(c);
    endtask

    // Caller must have lowered start; returns once every reply is in and
    // a settling wait has passed.
    task automatic wait_drained();
        while (board.expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // cfg_we is left high; load_regs lowers it after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        board.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic load_regs(input logic [31:0] lease, input logic [31:0] quiet,
                             input logic [2:0] host, input logic [1:0] afe);
        write_reg(lrhm_pkg::CFG_LEASE_TICKS, lease);
        write_reg(lrhm_pkg::CFG_QUIET_TICKS, quiet);
        write_reg(lrhm_pkg::CFG_HOST_USER, {29'd0, host});
        write_reg(lrhm_pkg::CFG_AFE_RAIL, {30'd0, afe});
        cfg_we <= 1'b0;
    endtask

    // Random sender gaps. A gap shorter than the block's busy time lets start
    // rise partway through an operation, so gaps land on every stage of it.
    // Once in a while the sender waits for all replies before going on.
    task automatic pause_sender(input bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady)
            return;
        if (roll < 2) begin
            start <= 1'b0;
            wait_drained();
        end else if (roll < 26) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    // Mostly valid rails and users with time creeping forward, so holds pile
    // up and leases and host silence actually run out; the rest is noise:
    // invalid indexes, spare func codes, time jumps and counter jumps.
    task automatic random_word();
        logic [2:0] f;
        logic [3:0] r;
        logic [3:0] u;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 34)
            f = lrhm_pkg::FN_ACQUIRE;
        else if (pick < 50)
            f = lrhm_pkg::FN_RELEASE;
        else if (pick < 60)
            f = lrhm_pkg::FN_HOLDS;
        else if (pick < 67)
            f = lrhm_pkg::FN_STATE;
        else if (pick < 92)
            f = lrhm_pkg::FN_POLL;
        else if (pick < 95)
            f = lrhm_pkg::FN_RELEASE_ALL;
        else
            f = $urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B;
        r = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, NR - 1))
                                         : 4'($urandom_range(NR, 15));
        u = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, NU - 1))
                                         : 4'($urandom_range(NU, 15));
        if ($urandom_range(0, 99) < 4)
            clock_now = $urandom();
        else
            clock_now = clock_now + $urandom_range(0, 400);
        pick = $urandom_range(0, 99);
        if (pick < 12)
            link_rx = link_rx + $urandom_range(1, 3);
        else if (pick < 15)
            link_rx = $urandom();
        send(f, r, u, clock_now, ($urandom_range(0, 99) < 35), link_rx,
             1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, register defaults: lease 3000, quiet 5000, host user 0, AFE rail 0.
        // plain lease
        send(lrhm_pkg::FN_ACQUIRE, 4'd1, 4'd2, 32'd1000, 1'b0, 32'd0, 1'b0);
        // new AFE hold, armed: refused
        send(lrhm_pkg::FN_ACQUIRE, 4'd0, 4'd3, 32'd1000, 1'b1, 32'd0, 1'b1);
        // AFE hold, drive goes high
        send(lrhm_pkg::FN_ACQUIRE, 4'd0, 4'd3, 32'd1000, 1'b0, 32'd0, 1'b1);
        // renewal while armed
        send(lrhm_pkg::FN_ACQUIRE, 4'd0, 4'd3, 32'd1000, 1'b1, 32'd0, 1'b0);
        // host: no lease
        send(lrhm_pkg::FN_ACQUIRE, 4'd0, 4'd0, 32'd1000, 1'b0, 32'd0, 1'b1);
        // bad rail
        send(lrhm_pkg::FN_ACQUIRE, 4'd15, 4'd2, 32'd1000, 1'b1, 32'd0, 1'b1);
        // bad user
        send(lrhm_pkg::FN_ACQUIRE, 4'd2, 4'd15, 32'd1000, 1'b0, 32'd0, 1'b0);
        send(lrhm_pkg::FN_HOLDS, 4'd1, 4'd2, 32'd1100, 1'b0, 32'd0, 1'b0);
        send(lrhm_pkg::FN_HOLDS, 4'd1, 4'd5, 32'd1100, 1'b0, 32'd0, 1'b0);
        // user ignored
        send(lrhm_pkg::FN_STATE, 4'd3, 4'd15, 32'd1100, 1'b1, 32'd0, 1'b1);
        // bad rail
        send(lrhm_pkg::FN_STATE, 4'd8, 4'd0, 32'd1100, 1'b0, 32'd0, 1'b0);
        // rail not left empty
        send(lrhm_pkg::FN_RELEASE, 4'd1, 4'd7, 32'd1200, 1'b0, 32'd0, 1'b0);
        // rail left empty
        send(lrhm_pkg::FN_RELEASE, 4'd1, 4'd2, 32'd1200, 1'b0, 32'd0, 1'b0);
        // expiry wraps to 0 -> 1
        send(lrhm_pkg::FN_ACQUIRE, 4'd2, 4'd4, 32'hFFFF_F448, 1'b0, 32'd0, 1'b0);
        // drops the wrapped lease
        send(lrhm_pkg::FN_POLL, 4'd2, 4'd4, 32'd2000, 1'b0, 32'd0, 1'b0);
        // host quiet + lease over
        send(lrhm_pkg::FN_POLL, 4'd15, 4'd15, 32'd6000, 1'b1, 32'd0, 1'b1);
        send(lrhm_pkg::FN_ACQUIRE, 4'd3, 4'd6, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
        // host heard
        send(lrhm_pkg::FN_POLL, 4'd3, 4'd6, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0);
        send(FN_SPARE_A, 4'd3, 4'd6, 32'd0, 1'b1, 32'd0, 1'b1);
        send(FN_SPARE_B, 4'd0, 4'd6, 32'd0, 1'b1, 32'd0, 1'b1);
        send(lrhm_pkg::FN_ACQUIRE, 4'd1, 4'd1, 32'd0, 1'b0, 32'd0, 1'b0);
        send(lrhm_pkg::FN_RELEASE_ALL, 4'd1, 4'd1, 32'd0, 1'b0, 32'd0, 1'b0);
        // counter changed back to 0
        send(lrhm_pkg::FN_POLL, 4'd0, 4'd0, 32'd0, 1'b0, 32'd0, 1'b0);
        start <= 1'b0;
        wait_drained();

        // Random part: one register setting per phase, written only with the block idle.
        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1) begin
                lease_set[p] = $urandom_range(100, 6000);
                quiet_set[p] = $urandom_range(500, 8000);
                host_set[p]  = 3'($urandom_range(0, 7));
                afe_set[p]   = 2'($urandom_range(0, 3));
            end
            load_regs(lease_set[p], quiet_set[p], host_set[p], afe_set[p]);
            clock_now = $urandom();
            link_rx   = $urandom();
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                pause_sender(p == STEADY_PHASE);
                random_word();
            end
            start <= 1'b0;
            wait_drained();
        end

        repeat (40) @(posedge clk);
        $display("Ran %0d commands over %0d register settings: %0d polls, %0d leases ran out.",
                 board.words_in, PHASES + 1, board.polls, board.lapsed);
        $display("Compared %0d reply words, %0d mismatches.",
                 board.replies_seen, board.errors);
        if (board.errors == 0 && board.expected_replies.size() == 0)
            $display("[leased_rail_hold_manager_top] OK");
        else
            $display("[leased_rail_hold_manager_top] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every word a full poll walk
    // plus the longest sender gap).
    initial
    begin
        #1_000_000;
        $display("Watchdog expired before the run finished.");
        $display("[leased_rail_hold_manager_top] ERROR");
        $finish;
    end

endmodule
